@@ rtl/dnf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_pkg: shared types and constants of the decimal number formatter
// Glyph codes, place powers of ten, divider sizing and the status struct
// passed from the divider to the sequencer.
// ----------------------------------------------------------------------------
package dnf_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int PLACE_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam int DATA_W     = 32;
  localparam int QUO_W      = 16;
  localparam int DIV_STEPS  = DATA_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [15:0] DIGIT_BASE0 = 16'h00a2;
  localparam logic [15:0] DIGIT_BASE1 = 16'h0121;
  localparam logic [15:0] SIGN_GLYPH0 = 16'h00f1;
  localparam logic [15:0] SIGN_GLYPH1 = 16'h01be;
  localparam logic [15:0] BLANK0      = 16'h0001;
  localparam logic [15:0] BLANK1      = 16'h01e2;
  localparam logic [15:0] OVF_GLYPH   = 16'h00e2;
  localparam logic [15:0] TERM_GLYPH  = 16'hffff;
  localparam logic [15:0] ERR_CODE    = 16'h0000;
  localparam logic [15:0] DIGIT_LIMIT = 16'd10;

  typedef enum logic [2:0] {
    GK_DIGIT,
    GK_SIGN,
    GK_BLANK,
    GK_TERM,
    GK_ERROR
  } glyph_kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // weight of a decimal place
  function automatic logic [DATA_W-1:0] pow10(input logic [PLACE_W-1:0] place);
    logic [DATA_W-1:0] p;
    case (place)
      PLACE_W'(0): p = 32'd1;
      PLACE_W'(1): p = 32'd10;
      PLACE_W'(2): p = 32'd100;
      PLACE_W'(3): p = 32'd1000;
      PLACE_W'(4): p = 32'd10000;
      PLACE_W'(5): p = 32'd100000;
      PLACE_W'(6): p = 32'd1000000;
      PLACE_W'(7): p = 32'd10000000;
      PLACE_W'(8): p = 32'd100000000;
      PLACE_W'(9): p = 32'd1000000000;
      default:     p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/decimal_number_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_formatter: signed 32-bit integer to decimal glyph run
// Sequencer, bit-serial place divider, glyph encoder and output register.
// ----------------------------------------------------------------------------
// One input word is taken at a time and turned into a run of glyph words:
// a sign glyph for negatives, one glyph per decimal place from the top
// (suppressed, blanked or zero padded by pad mode), then the terminator
// 0xffff flagged last. If capacity is not above digit count plus sign, a
// single word with overflow_error and last set is sent instead. Each place
// is worked out by the 32-step bit-serial divider, with its start, hand-over
// and emit states around it, and the run holds while the output is stalled.
// The digit count is clamped to 1..10. The next word is taken as soon as the
// terminator sits in the output register.
// ----------------------------------------------------------------------------
module decimal_number_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_value,
  input  logic [3:0]  in_digit_count,
  input  logic [1:0]  in_pad_mode,
  input  logic        in_glyph_set,
  input  logic [15:0] in_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char_code,
  output logic        out_last,
  output logic        out_overflow_error
);
  import dnf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HEAD  = 6'b000010,
    S_START = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_TERM  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // item context
  logic [DATA_W-1:0]  mag_r, mag_nxt;
  logic [QUO_W-1:0]   d_r, d_nxt;
  logic [PLACE_W-1:0] place_r, place_nxt;
  logic               neg_r, neg_nxt;
  logic               fit_r, fit_nxt;
  logic               set_r, set_nxt;
  logic               blank_r, blank_nxt;
  logic               zp_r, zp_nxt;   // digits now shown, zeros included

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_code_r;
  logic        out_last_r;
  logic        out_err_r;

  // input decode
  logic [31:0] in_raw;
  logic        in_neg;
  logic [31:0] in_mag;
  logic [3:0]  n_cl;
  logic [15:0] need_cap;

  // emit path
  logic        slot_free;
  logic        emit;
  glyph_kind_t emit_kind;
  logic        emit_last;
  logic        emit_err;
  logic [15:0] emit_code;
  logic        show;

  // divider
  logic              div_start;
  div_stat_t         div_st;
  logic [QUO_W-1:0]  div_quot;
  logic [DATA_W-1:0] div_rem;

  always_comb begin
    in_raw = in_value;
    in_neg = in_raw[31];
    in_mag = in_neg ? (~in_raw + 32'd1) : in_raw;
    if (in_digit_count == 4'd0) begin
      n_cl = 4'd1;
    end else if (in_digit_count > 4'(MAX_DIGITS)) begin
      n_cl = 4'(MAX_DIGITS);
    end else begin
      n_cl = in_digit_count;
    end
    need_cap = {12'h000, n_cl} + {15'h0000, in_neg};
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign show      = zp_r || (d_r != '0) || (place_r == '0);

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    d_nxt     = d_r;
    place_nxt = place_r;
    neg_nxt   = neg_r;
    fit_nxt   = fit_r;
    set_nxt   = set_r;
    blank_nxt = blank_r;
    zp_nxt    = zp_r;
    emit      = 1'b0;
    emit_kind = GK_TERM;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_neg;
          fit_nxt   = (in_capacity > need_cap);
          set_nxt   = in_glyph_set;
          blank_nxt = (in_pad_mode == 2'd1);
          zp_nxt    = (in_pad_mode == 2'd2);   // pad mode three acts as mode 0
          place_nxt = PLACE_W'(n_cl - 4'd1);
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!fit_r) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = GK_ERROR;
            emit_last = 1'b1;
            emit_err  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (neg_r) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_kind = GK_SIGN;
            state_nxt = S_START;
          end
        end else begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          mag_nxt   = div_rem;
          d_nxt     = div_quot;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!(show || blank_r) || slot_free) begin
          if (show) begin
            emit      = 1'b1;
            emit_kind = GK_DIGIT;
            zp_nxt    = 1'b1;
          end else if (blank_r) begin
            emit      = 1'b1;
            emit_kind = GK_BLANK;
          end
          if (place_r == '0) begin
            state_nxt = S_TERM;
          end else begin
            place_nxt = place_r - 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = GK_TERM;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  dnf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (pow10(place_r)),
    .stat     (div_st),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  dnf_glyph u_glyph (
    .kind  (emit_kind),
    .digit (d_r),
    .set   (set_r),
    .code  (emit_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    d_r     <= d_nxt;
    place_r <= place_nxt;
    neg_r   <= neg_nxt;
    fit_r   <= fit_nxt;
    set_r   <= set_nxt;
    blank_r <= blank_nxt;
    zp_r    <= zp_nxt;
    if (emit) begin
      out_code_r <= emit_code;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_char_code      = out_code_r;
  assign out_last           = out_last_r;
  assign out_overflow_error = out_err_r;

  // divider only runs while the sequencer waits on it
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider result with no one waiting");

  // an accepted word always starts at the head
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_HEAD))
    else $error("accepted word did not start a run");

  // error word is always the whole run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow_error) |-> out_last)
    else $error("error word not flagged last");

endmodule

@@ rtl/dnf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_div: bit-serial place divider
// Restoring division, one quotient bit per cycle. Keeps the low 16 quotient
// bits and returns dividend - divisor * (quotient mod 2^16), mod 2^32.
// ----------------------------------------------------------------------------
module dnf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dnf_pkg::DATA_W-1:0] dividend,
  input  logic [dnf_pkg::DATA_W-1:0] divisor,
  output dnf_pkg::div_stat_t        stat,
  output logic [dnf_pkg::QUO_W-1:0] quot,
  output logic [dnf_pkg::DATA_W-1:0] rem
);
  import dnf_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0] dvd_r;
  logic [DATA_W-1:0] dsr_r;
  logic [DATA_W-1:0] par_r;
  logic [QUO_W-1:0]  quo_r;
  logic [QUO_W-1:0]  z_r;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic              hi_bit;
  logic [DATA_W-1:0] par_nxt;
  logic [QUO_W-1:0]  z_nxt;

  always_comb begin
    trial   = {par_r, dvd_r[DATA_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = (trial >= {1'b0, dsr_r});
    par_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    // quotient bits above the kept field: fold divisor * 2^j back in
    hi_bit  = (cnt_r < CNT_W'(DIV_STEPS - QUO_W));
    if (hi_bit) begin
      z_nxt = {z_r[QUO_W-2:0], 1'b0} + (ge ? dsr_r[QUO_W-1:0] : {QUO_W{1'b0}});
    end else begin
      z_nxt = z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      par_r <= '0;
      quo_r <= '0;
      z_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
      par_r <= par_nxt;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      z_r   <= z_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem       = par_r + {z_r, {(DATA_W - QUO_W){1'b0}}};

endmodule

@@ rtl/dnf_glyph.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_glyph: glyph code encoder
// Maps a glyph kind, place quotient and glyph set to the emitted code.
// ----------------------------------------------------------------------------
module dnf_glyph (
  input  dnf_pkg::glyph_kind_t      kind,
  input  logic [dnf_pkg::QUO_W-1:0] digit,
  input  logic                      set,
  output logic [15:0]               code
);
  import dnf_pkg::*;

  logic [15:0] base;

  always_comb begin
    base = set ? DIGIT_BASE1 : DIGIT_BASE0;
    case (kind)
      GK_DIGIT: begin
        if (digit >= DIGIT_LIMIT) begin
          code = OVF_GLYPH;
        end else begin
          code = base + {12'h000, digit[3:0]};
        end
      end
      GK_SIGN:  code = set ? SIGN_GLYPH1 : SIGN_GLYPH0;
      GK_BLANK: code = set ? BLANK1 : BLANK0;
      GK_TERM:  code = TERM_GLYPH;
      GK_ERROR: code = ERR_CODE;
      default:  code = ERR_CODE;
    endcase
  end

endmodule

@@ dv/dnf_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnf_tb_pkg: verification types for the decimal number formatter
// Padding mode codes, shared by the stimulus and the checker, and the
// layout of one result word used by the checker.
// ----------------------------------------------------------------------------
package dnf_tb_pkg;

  typedef enum logic [1:0] {
    PAD_LEFT  = 2'd0,
    PAD_BLANK = 2'd1,
    PAD_ZERO  = 2'd2,
    PAD_RSVD  = 2'd3
  } pad_mode_t;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
    logic        err;
  } glyph_word_t;

endpackage

@@ dv/decimal_number_formatter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_formatter_checker: glyph run predictor and scoreboard
// Watches both channels, builds the expected glyph words for every accepted
// input word and compares each accepted output word with the oldest one.
// ----------------------------------------------------------------------------
module decimal_number_formatter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_digit_count,
  input  logic [1:0]  in_pad_mode,
  input  logic        in_glyph_set,
  input  logic [15:0] in_capacity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_char_code,
  input  logic        out_last,
  input  logic        out_overflow_error,
  output int          fail_count,
  output int          pending_count
);

  import dnf_pkg::*;
  import dnf_tb_pkg::*;

  glyph_word_t glyphs_due[$];
  int          n_fail = 0;

  function automatic void queue_glyph(logic [15:0] code, logic last, logic err);
    glyph_word_t w;
    w.code = code;
    w.last = last;
    w.err  = err;
    glyphs_due.push_back(w);
  endfunction

  // expected glyph run for one input word
  function automatic void predict_run(logic [31:0] v, logic [3:0] count, logic [1:0] pad,
                                      logic set, logic [15:0] cap);
    logic              neg;
    int unsigned       n;
    logic [31:0]       mag;
    logic [31:0]       weight;
    logic [31:0]       rem;
    logic [15:0]       quo;
    logic [15:0]       shown;
    pad_mode_t         mode;
    neg  = v[31];
    n    = count;
    mode = pad_mode_t'(pad);
    if (n < 1) n = 1;
    if (n > MAX_DIGITS) n = MAX_DIGITS;

    if (!(32'(cap) > n + 32'(neg))) begin
      queue_glyph(ERR_CODE, 1'b1, 1'b1);
      return;
    end

    // magnitude wraps, so the most negative value stays 2^31
    mag = neg ? (32'd0 - v) : v;
    if (neg) queue_glyph(set ? SIGN_GLYPH1 : SIGN_GLYPH0, 1'b0, 1'b0);

    weight = 32'd1;
    for (int k = 1; k < n; k++) weight = weight * 32'd10;

    while (weight != 32'd0) begin
      quo   = 16'(mag / weight);
      rem   = mag - weight * {16'd0, quo};
      shown = (quo >= DIGIT_LIMIT) ? OVF_GLYPH : ((set ? DIGIT_BASE1 : DIGIT_BASE0) + quo);
      if (mode == PAD_ZERO) begin
        queue_glyph(shown, 1'b0, 1'b0);
      end else if (quo != 16'd0 || weight == 32'd1) begin
        // first significant place: everything below is shown
        mode = PAD_ZERO;
        queue_glyph(shown, 1'b0, 1'b0);
      end else if (mode == PAD_BLANK) begin
        queue_glyph(set ? BLANK1 : BLANK0, 1'b0, 1'b0);
      end
      mag    = rem;
      weight = weight / 32'd10;
    end

    queue_glyph(TERM_GLYPH, 1'b1, 1'b0);
  endfunction

  always @(posedge clk) begin : watch
    glyph_word_t got;
    glyph_word_t due;
    if (rst_n) begin
      // output first, so a word can never match an input taken at the same edge
      if (out_valid && !out_stall) begin
        got.code = out_char_code;
        got.last = out_last;
        got.err  = out_overflow_error;
        if (glyphs_due.size() == 0) begin
          if (n_fail < 10)
            $display("%0t: unexpected word: code %h last %b err %b",
                     $realtime, got.code, got.last, got.err);
          n_fail++;
        end else begin
          due = glyphs_due.pop_front();
          if (got.code !== due.code || got.last !== due.last || got.err !== due.err) begin
            if (n_fail < 10)
              $display("%0t: mismatch: expected code %h last %b err %b, got code %h last %b err %b",
                       $realtime, due.code, due.last, due.err, got.code, got.last, got.err);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_run(in_value, in_digit_count, in_pad_mode, in_glyph_set, in_capacity);
    end
    fail_count    <= n_fail;
    pending_count <= glyphs_due.size();
  end

endmodule

@@ dv/decimal_number_formatter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_number_formatter_tb: top level of the formatter testbench
// Drives directed corner words then random words through three idling
// phases; the checker beside the block predicts and compares every glyph.
// ----------------------------------------------------------------------------
module decimal_number_formatter_tb;

  import dnf_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_value;
  logic [3:0]  in_digit_count;
  logic [1:0]  in_pad_mode;
  logic        in_glyph_set;
  logic [15:0] in_capacity;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_char_code;
  logic        out_last;
  logic        out_overflow_error;

  int fail_count;
  int pending_count;

  // idling odds in percent, changed per phase
  int send_idle_pct  = 29;
  int recv_stall_pct = 88;

  decimal_number_formatter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_digit_count     (in_digit_count),
    .in_pad_mode        (in_pad_mode),
    .in_glyph_set       (in_glyph_set),
    .in_capacity        (in_capacity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_code      (out_char_code),
    .out_last           (out_last),
    .out_overflow_error (out_overflow_error)
  );

  decimal_number_formatter_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_digit_count     (in_digit_count),
    .in_pad_mode        (in_pad_mode),
    .in_glyph_set       (in_glyph_set),
    .in_capacity        (in_capacity),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_code      (out_char_code),
    .out_last           (out_last),
    .out_overflow_error (out_overflow_error),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one word. Idle cycles go first with valid low; once raised, valid
  // and the payload hold until the word is taken, so valid never looks at
  // the stall. Back-to-back words keep valid high with a single assignment.
  task automatic offer_word(logic [31:0] v, logic [3:0] count, pad_mode_t pad,
                            logic set, logic [15:0] cap);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    in_digit_count <= count;
    in_pad_mode    <= pad;
    in_glyph_set   <= set;
    in_capacity    <= cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] v;
    logic [31:0] weight;
    logic [3:0]  count;
    logic [15:0] cap;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_digit_count <= 4'd1;
    in_pad_mode    <= PAD_LEFT;
    in_glyph_set   <= 1'b0;
    in_capacity    <= '0;
    rst_n          <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners --------------------------------------------------
    // zero in the left, blank and zero padding modes, one place and full width
    offer_word(32'd0, 4'd1, PAD_LEFT, 1'b0, 16'd2);
    offer_word(32'd0, 4'd10, PAD_BLANK, 1'b1, 16'd11);
    offer_word(32'd0, 4'd10, PAD_ZERO, 1'b0, 16'd11);
    // largest and smallest values at full width
    offer_word(32'h7fff_ffff, 4'd10, PAD_LEFT, 1'b0, 16'd11);
    offer_word(32'h7fff_ffff, 4'd10, PAD_ZERO, 1'b1, 16'hffff);
    offer_word(32'h8000_0000, 4'd10, PAD_BLANK, 1'b0, 16'd12);
    // most negative value where the sign tips it over capacity
    offer_word(32'h8000_0000, 4'd10, PAD_ZERO, 1'b1, 16'd11);
    // minus one: fits just, then one short
    offer_word(32'hffff_ffff, 4'd1, PAD_LEFT, 1'b1, 16'd3);
    offer_word(32'hffff_ffff, 4'd1, PAD_LEFT, 1'b0, 16'd2);
    // top place quotient above nine gives the overflow glyph
    offer_word(32'd12345, 4'd3, PAD_LEFT, 1'b0, 16'd4);
    // quotient of 0xffff after truncation, remainder wraps
    offer_word(32'h7fff_ffff, 4'd1, PAD_BLANK, 1'b1, 16'd2);
    // truncation hides the overflow: 3 * 65536 + 7 shows as seven
    offer_word(32'd196615, 4'd1, PAD_ZERO, 1'b0, 16'd100);
    // digit count zero acts as one, above the maximum acts as ten
    offer_word(32'd42, 4'd0, PAD_ZERO, 1'b0, 16'd5);
    offer_word(-32'sd987654321, 4'd15, PAD_BLANK, 1'b1, 16'd20);
    // reserved pad mode behaves as left aligned
    offer_word(32'd1000, 4'd6, PAD_RSVD, 1'b0, 16'd10);
    offer_word(32'd1000, 4'd6, PAD_RSVD, 1'b1, 16'd10);
    // no room at all first; the words after it fit
    offer_word(32'd5, 4'd3, PAD_LEFT, 1'b0, 16'd0);
    offer_word(32'd1000000000, 4'd10, PAD_LEFT, 1'b1, 16'd11);
    offer_word(-32'sd999999999, 4'd9, PAD_BLANK, 1'b0, 16'd11);
    offer_word(-32'sd10, 4'd2, PAD_ZERO, 1'b1, 16'd4);
    offer_word(32'd100, 4'd5, PAD_BLANK, 1'b0, 16'd6);
    // capacity boundary on both sides
    offer_word(32'd7, 4'd5, PAD_LEFT, 1'b0, 16'd6);
    offer_word(32'd7, 4'd5, PAD_LEFT, 1'b0, 16'd5);

    // ---- random words, three idling phases ---------------------------------
    for (int w = 0; w < 107; w++) begin
      if (w == 36) begin
        send_idle_pct  = 88;
        recv_stall_pct = 29;
      end else if (w == 72) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 99999);
        2: v = 32'd0 - 32'($urandom_range(0, 99999));
        default: begin
          // just around a power of ten, either sign
          weight = 32'd1;
          repeat ($urandom_range(0, 9)) weight = weight * 32'd10;
          v = weight + 32'($urandom_range(0, 4)) - 32'd2;
          if ($urandom_range(0, 1) != 0) v = 32'd0 - v;
        end
      endcase

      // mostly legal counts, now and then the clamped ones
      if ($urandom_range(0, 9) == 0) count = 4'($urandom_range(0, 15));
      else count = 4'($urandom_range(1, 10));

      case ($urandom_range(0, 3))
        0: cap = 16'($urandom_range(0, 14));   // around the fit boundary
        1, 2: cap = 16'($urandom_range(12, 40));
        default: cap = 16'($urandom);
      endcase

      offer_word(v, count, pad_mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), cap);
    end

    // ---- drain and verdict -------------------------------------------------
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ decimal_number_formatter.f @@
rtl/dnf_pkg.sv
rtl/dnf_div.sv
rtl/dnf_glyph.sv
rtl/decimal_number_formatter.sv
dv/dnf_tb_pkg.sv
dv/decimal_number_formatter_checker.sv
dv/decimal_number_formatter_tb.sv
